// File: sv/gips_pkg.sv
// Shared package for the grouped id pair set table.
// Holds the command codes, controller states, command/status structs and bus widths.
// Depends on nothing; every other file refers to it by scoped names.
package gips_pkg;

    localparam int DEF_MAX_GROUPS  = 16;
    localparam int DEF_MAX_MEMBERS = 16;

    localparam int CMD_W       = 2;
    localparam int ID_W        = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;
    localparam int RES_W       = 3;

    localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] OP_CHECK  = 2'd1;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GSRCH,
        ST_MSRCH,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic g_next;
        logic g_take;
        logic m_step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic g_end;
        logic g_hit;
        logic m_end;
        logic m_hit;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/gips_ctrl.sv
// Controller state machine of the grouped id pair set table.
// Sequences the group search, the member search and the final update.
// Depends on gips_pkg.
module gips_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [gips_pkg::CMD_W-1:0]    in_cmd,
    output logic                          in_ready,
    input  gips_pkg::dp_stat_t            stat,
    output gips_pkg::dp_cmd_t             cmd
);

    gips_pkg::state_t state_reg;
    gips_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gips_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            gips_pkg::ST_IDLE: begin
                // Nothing is taken while the block is held in reset.
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd.load = 1'b1;
                    if (in_cmd == gips_pkg::OP_INSERT || in_cmd == gips_pkg::OP_CHECK) begin
                        state_next = gips_pkg::ST_GSRCH;
                    end else begin
                        state_next = gips_pkg::ST_FINISH;
                    end
                end
            end
            gips_pkg::ST_GSRCH: begin
                if (stat.g_hit) begin
                    cmd.g_take = 1'b1;
                    state_next = gips_pkg::ST_MSRCH;
                end else if (stat.g_end) begin
                    state_next = gips_pkg::ST_FINISH;
                end else begin
                    cmd.g_next = 1'b1;
                end
            end
            gips_pkg::ST_MSRCH: begin
                cmd.m_step = 1'b1;
                if (stat.m_hit || stat.m_end) begin
                    state_next = gips_pkg::ST_FINISH;
                end
            end
            gips_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = gips_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gips_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/gips_dp.sv
// Datapath of the grouped id pair set table: group table, member counts,
// member memory, search counters and the output register.
// Depends on gips_pkg.
module gips_dp #(
    parameter int MAX_GROUPS  = gips_pkg::DEF_MAX_GROUPS,
    parameter int MAX_MEMBERS = gips_pkg::DEF_MAX_MEMBERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gips_pkg::CMD_W-1:0]    in_cmd,
    input  logic [gips_pkg::ID_W-1:0]     in_gid,
    input  logic [gips_pkg::ID_W-1:0]     in_mid,
    input  gips_pkg::dp_cmd_t             cmd,
    output gips_pkg::dp_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gips_pkg::RES_W-1:0]    out_res
);

    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW  = $clog2(MAX_GROUPS + 1);
    localparam int MW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int MCW = $clog2(MAX_MEMBERS + 1);
    localparam int AW  = GW + MW;

    logic [gips_pkg::CMD_W-1:0] op_reg;
    logic [gips_pkg::ID_W-1:0]  gid_reg;
    logic [gips_pkg::ID_W-1:0]  mid_reg;
    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              gc_reg;
    logic [GW-1:0]              slot_reg;
    logic [MCW-1:0]             n_reg;
    logic [MCW-1:0]             k_reg;
    logic                       pend_reg;
    logic                       found_reg;
    logic                       present_reg;
    logic [gips_pkg::ID_W-1:0]  rdata_reg;
    logic                       out_valid_reg;
    logic [gips_pkg::RES_W-1:0] out_res_reg;

    logic [gips_pkg::ID_W-1:0]  group_ids [MAX_GROUPS];
    logic [MCW-1:0]             mcount    [MAX_GROUPS];
    logic [gips_pkg::ID_W-1:0]  member_mem [2**AW];

    logic [GW-1:0] i_idx;
    logic [GW-1:0] gc_idx;
    logic          is_ins;
    logic          is_chk;
    logic          n_room;
    logic          g_room;
    logic          ins_new;
    logic          add_mem;
    logic          add_grp;
    logic          res_full;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    assign i_idx  = i_reg[GW-1:0];
    assign gc_idx = gc_reg[GW-1:0];

    assign stat.g_end    = (i_reg == gc_reg);
    assign stat.g_hit    = !stat.g_end && (group_ids[i_idx] == gid_reg);
    assign stat.m_hit    = pend_reg && (rdata_reg == mid_reg);
    assign stat.m_end    = !pend_reg && (k_reg == n_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign is_ins  = (op_reg == gips_pkg::OP_INSERT);
    assign is_chk  = (op_reg == gips_pkg::OP_CHECK);
    assign n_room  = (n_reg < MCW'(MAX_MEMBERS));
    assign g_room  = (gc_reg < CW'(MAX_GROUPS));
    assign ins_new = is_ins && !present_reg;
    assign add_mem = cmd.finish && ins_new && found_reg && n_room;
    assign add_grp = cmd.finish && ins_new && !found_reg && g_room;
    assign res_full = ins_new && (found_reg ? !n_room : !g_room);

    assign mem_re = cmd.m_step && (k_reg != n_reg);
    assign raddr  = {slot_reg, k_reg[MW-1:0]};
    assign mem_we = add_mem || add_grp;
    assign waddr  = add_mem ? {slot_reg, n_reg[MW-1:0]} : {gc_idx, MW'(0)};

    // Member memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            member_mem[waddr] <= mid_reg;
        end
        if (mem_re) begin
            rdata_reg <= member_mem[raddr];
        end
    end

    // Group table and per-group member counts.
    always_ff @(posedge aclk) begin
        if (add_grp) begin
            group_ids[gc_idx] <= gid_reg;
            mcount[gc_idx]    <= MCW'(1);
        end else if (add_mem) begin
            mcount[slot_reg] <= n_reg + MCW'(1);
        end
    end

    // Item fields and search bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_cmd;
            gid_reg     <= in_gid;
            mid_reg     <= in_mid;
            i_reg       <= '0;
            found_reg   <= 1'b0;
            present_reg <= 1'b0;
        end
        if (cmd.g_next) begin
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.g_take) begin
            slot_reg  <= i_idx;
            n_reg     <= mcount[i_idx];
            k_reg     <= '0;
            found_reg <= 1'b1;
        end
        if (cmd.m_step) begin
            if (stat.m_hit) begin
                present_reg <= 1'b1;
            end
            if (mem_re) begin
                k_reg <= k_reg + MCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            gc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.g_take) begin
                pend_reg <= 1'b0;
            end else if (cmd.m_step) begin
                pend_reg <= mem_re;
            end
            if (add_grp) begin
                gc_reg <= gc_reg + CW'(1);
            end else if (cmd.finish && op_reg == gips_pkg::OP_CLEAR) begin
                gc_reg <= '0;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result flags, lowest bit first: present, added, full.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_res_reg <= {res_full, add_mem || add_grp,
                            (is_ins || is_chk) && present_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// File: sv/grouped_id_pair_set_table.sv
// Top level of the grouped id pair set table.
// Joins the controller gips_ctrl and the datapath gips_dp; depends on gips_pkg.
//
// The block keeps a set of (group id, member id) pairs. Each input beat on the
// s_ channel carries a command: insert a pair, check a pair, or clear the whole
// table (the unused command code is accepted and answered with all flags low).
// Every input beat produces exactly one result beat on the m_ channel, holding
// the present, added and full flags.
// Items are handled one at a time. After a beat is accepted, s_tready stays low
// while the group table is scanned one entry per cycle and then the member list
// of the matching group is read from the member memory, one entry per cycle,
// through its registered read port. A clear or unused command skips both
// searches and goes straight to the final step. The next beat can be taken
// in the cycle after the result is registered.
// The result sits in an output register. If the receiver stalls, the finished
// item waits in the final step until the register is free, and the next input
// beat is taken only once that item has been handed over.
// Reset empties the table at once (the group count is cleared) and holds
// s_tready low; the member memory and group ids need no clearing since only
// counted entries are read.
module grouped_id_pair_set_table #(
    parameter int MAX_GROUPS  = gips_pkg::DEF_MAX_GROUPS,
    parameter int MAX_MEMBERS = gips_pkg::DEF_MAX_MEMBERS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: cmd[1:0], group_id[17:2], member_id[33:18], zeros.
    input  logic [gips_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: present[0], added[1], full_res[2], zeros.
    output logic [gips_pkg::M_TDATA_W-1:0]    m_tdata
);

    gips_pkg::dp_cmd_t  dp_cmd;
    gips_pkg::dp_stat_t dp_stat;

    logic [gips_pkg::CMD_W-1:0] in_cmd;
    logic [gips_pkg::ID_W-1:0]  in_gid;
    logic [gips_pkg::ID_W-1:0]  in_mid;
    logic [gips_pkg::RES_W-1:0] res;

    // Unpack the input beat.
    assign in_cmd = s_tdata[gips_pkg::CMD_W-1:0];
    assign in_gid = s_tdata[gips_pkg::CMD_W +: gips_pkg::ID_W];
    assign in_mid = s_tdata[gips_pkg::CMD_W + gips_pkg::ID_W +: gips_pkg::ID_W];

    gips_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (in_cmd),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    gips_dp #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (in_cmd),
        .in_gid    (in_gid),
        .in_mid    (in_mid),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pad the three result flags up to a whole byte.
    assign m_tdata = {{(gips_pkg::M_TDATA_W - gips_pkg::RES_W){1'b0}}, res};

endmodule

// File: sv/gips_check.sv
// Port-level checker for the grouped id pair set table, with its bind statement.
// Depends on gips_pkg and on the top level grouped_id_pair_set_table.
module gips_check (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [gips_pkg::S_TDATA_W-1:0]    s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gips_pkg::M_TDATA_W-1:0]    m_tdata
);

    // At most one of present, added and full is reported for any item.
    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[gips_pkg::RES_W-1:0]) <= 1)
        else $error("more than one result flag set");

    // Padding bits of the result beat stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[gips_pkg::M_TDATA_W-1:gips_pkg::RES_W] == '0)
        else $error("result padding not zero");

    // Items are taken one at a time: no beat is accepted in the cycle after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // No result is offered straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind grouped_id_pair_set_table gips_check u_gips_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
